// ----- design/cdic_pkg.sv -----
// Shared types and codes for the cascaded interrupt controller pair.
// No dependencies; imported by cascaded_dual_interrupt_controller_unit.
package cdic_pkg;

    localparam int unsigned NUM_CHIPS   = 2;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned S_USER_W    = 2;
    localparam int unsigned M_DATA_W    = 24;
    localparam int unsigned M_USER_W    = 2;

    typedef enum logic [1:0] {
        ACT_RAISE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ICW2   = 2'd1,
        PH_ICW3   = 2'd2,
        PH_ICW4   = 2'd3
    } init_phase_t;

    localparam logic [7:0] CMD_READ_IRR  = 8'h0A;
    localparam logic [7:0] CMD_READ_ISR  = 8'h0B;
    localparam logic [7:0] CMD_EOI       = 8'h20;
    localparam logic [7:0] CMD_SEOI      = 8'h60;
    localparam logic [7:0] CMD_SEOI_MASK = 8'hF8;
    localparam int unsigned ICW1_BIT     = 4;
    localparam logic [3:0] IRQ_CASCADE   = 4'd2;
    localparam logic [7:0] MASK_ALL      = 8'hFF;
    localparam logic [4:0] BASE_MASTER   = 5'd1;
    localparam logic [4:0] BASE_SLAVE    = 5'd14;

    typedef struct packed {
        logic [3:0] irq_line;
        logic [7:0] write_data;
        logic       port_offset;
        logic       chip_select;
        action_t    action;
    } item_t;

    typedef struct packed {
        logic [4:0] int_request;
        logic       bad_irq;
        logic       vector_valid;
        logic [7:0] vector;
        logic [7:0] read_data;
    } result_t;

    // Highest-priority ready line plus one, order 0,1,8..15,2..7; zero if none
    function automatic logic [4:0] encode_priority(input logic [7:0] m_rdy,
                                                   input logic [7:0] s_rdy);
        logic [4:0] r;
        r = '0;
        for (int b = 7; b >= 2; b--) begin
            if (m_rdy[b]) r = 5'(b + 1);
        end
        for (int b = 7; b >= 0; b--) begin
            if (s_rdy[b]) r = 5'(b + 9);
        end
        if (m_rdy[1]) r = 5'd2;
        if (m_rdy[0]) r = 5'd1;
        return r;
    endfunction

endpackage

// ----- design/cascaded_dual_interrupt_controller_unit.sv -----
// Throughput: one item per cycle while the result output is not stalled.
// An input register holds the item, one pass of logic updates both chips and
// the pending line, and a result register holds the outcome until taken.
// aresetn (synchronous, active low) clears requests and in-service bits, masks
// all lines, restores vector bases (master 1, slave 14) and empties both stages.
// Depends on cdic_pkg.
module cascaded_dual_interrupt_controller_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // chip_select[0], port_offset[1], write_data[9:2], irq_line[13:10], zeros above
    input  logic [cdic_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [cdic_pkg::S_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data[7:0], vector[15:8], int_request[20:16], zeros above
    output logic [cdic_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // vector_valid[0], bad_irq[1]
    output logic [cdic_pkg::M_USER_W-1:0]    m_axis_tuser
);
    import cdic_pkg::*;

    logic          in_valid_reg;
    item_t         in_item_reg;
    logic          out_valid_reg;
    result_t       out_res_reg;
    result_t       res_next;
    logic          advance;
    logic          fire;

    logic [7:0]    irr_reg   [NUM_CHIPS];
    logic [7:0]    isr_reg   [NUM_CHIPS];
    logic [7:0]    imr_reg   [NUM_CHIPS];
    logic [4:0]    base_reg  [NUM_CHIPS];
    logic          rss_reg   [NUM_CHIPS];
    init_phase_t   phase_reg [NUM_CHIPS];
    logic          icw4_reg  [NUM_CHIPS];
    logic [4:0]    pend_reg;

    logic [7:0]    irr_next   [NUM_CHIPS];
    logic [7:0]    isr_next   [NUM_CHIPS];
    logic [7:0]    imr_next   [NUM_CHIPS];
    logic [4:0]    base_next  [NUM_CHIPS];
    logic          rss_next   [NUM_CHIPS];
    init_phase_t   phase_next [NUM_CHIPS];
    logic          icw4_next  [NUM_CHIPS];
    logic [4:0]    pend_next;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        logic [4:0] ack_p;
        logic [3:0] ack_n;
        logic       ack_hit;
        logic       reload;
        logic       sel;
        logic [7:0] d;
        logic [7:0] rdy_m;
        logic [7:0] rdy_s;

        d       = in_item_reg.write_data;
        sel     = in_item_reg.chip_select;
        ack_p   = encode_priority(irr_reg[0] & ~isr_reg[0] & ~imr_reg[0],
                                  irr_reg[1] & ~isr_reg[1] & ~imr_reg[1]);
        ack_n   = 4'(ack_p - 5'd1);
        ack_hit = (in_item_reg.action == ACT_ACK) && (ack_p != '0);
        reload  = 1'b0;
        res_next = '0;

        for (int c = 0; c < NUM_CHIPS; c++) begin
            irr_next[c]   = irr_reg[c];
            isr_next[c]   = isr_reg[c];
            imr_next[c]   = imr_reg[c];
            base_next[c]  = base_reg[c];
            rss_next[c]   = rss_reg[c];
            phase_next[c] = phase_reg[c];
            icw4_next[c]  = icw4_reg[c];

            if (in_item_reg.action == ACT_RAISE && in_item_reg.irq_line != IRQ_CASCADE
                    && in_item_reg.irq_line[3] == 1'(c)) begin
                irr_next[c] = irr_reg[c] | (8'd1 << in_item_reg.irq_line[2:0]);
                reload      = 1'b1;
            end

            if (in_item_reg.action == ACT_WRITE && sel == 1'(c)) begin
                if (!in_item_reg.port_offset) begin
                    priority if (d[ICW1_BIT]) begin
                        phase_next[c] = PH_ICW2;
                        imr_next[c]   = MASK_ALL;
                        isr_next[c]   = '0;
                        irr_next[c]   = '0;
                        icw4_next[c]  = d[0];
                    end else if (d == CMD_READ_IRR) begin
                        rss_next[c] = 1'b0;
                    end else if (d == CMD_READ_ISR) begin
                        rss_next[c] = 1'b1;
                    end else if (d == CMD_EOI) begin
                        isr_next[c] = isr_reg[c] & (isr_reg[c] - 8'd1);
                        reload      = 1'b1;
                    end else if ((d & CMD_SEOI_MASK) == CMD_SEOI) begin
                        isr_next[c] = isr_reg[c] & ~(8'd1 << d[2:0]);
                        reload      = 1'b1;
                    end else begin
                        // Drop unknown commands
                        rss_next[c] = rss_reg[c];
                    end
                end else begin
                    unique case (phase_reg[c])
                        PH_NORMAL: imr_next[c] = d;
                        PH_ICW2: begin
                            base_next[c]  = d[7:3];
                            phase_next[c] = PH_ICW3;
                        end
                        PH_ICW3:   phase_next[c] = icw4_reg[c] ? PH_ICW4 : PH_NORMAL;
                        default:   phase_next[c] = PH_NORMAL;
                    endcase
                end
            end

            if (ack_hit && ack_n[3] == 1'(c)) begin
                isr_next[c] = isr_reg[c] | (8'd1 << ack_n[2:0]);
                irr_next[c] = irr_reg[c] & ~(8'd1 << ack_n[2:0]);
            end
        end

        rdy_m = irr_next[0] & ~isr_next[0] & ~imr_next[0];
        rdy_s = irr_next[1] & ~isr_next[1] & ~imr_next[1];

        priority if (ack_hit) begin
            pend_next = '0;
        end else if (reload) begin
            pend_next = encode_priority(rdy_m, rdy_s);
        end else begin
            pend_next = pend_reg;
        end

        unique case (in_item_reg.action)
            ACT_RAISE: res_next.bad_irq = (in_item_reg.irq_line == IRQ_CASCADE);
            ACT_READ: begin
                if (in_item_reg.port_offset) begin
                    res_next.read_data = sel ? imr_reg[1] : imr_reg[0];
                end else if (sel) begin
                    res_next.read_data = rss_reg[1] ? isr_reg[1] : irr_reg[1];
                end else begin
                    res_next.read_data = rss_reg[0] ? isr_reg[0] : irr_reg[0];
                end
            end
            ACT_WRITE: res_next.read_data = '0;
            ACT_ACK: begin
                if (ack_hit) begin
                    res_next.vector_valid = 1'b1;
                    res_next.vector = {(ack_n[3] ? base_reg[1] : base_reg[0]), ack_n[2:0]};
                end
            end
            default: res_next.read_data = '0;
        endcase
        res_next.int_request = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
            for (int c = 0; c < NUM_CHIPS; c++) begin
                irr_reg[c]   <= '0;
                isr_reg[c]   <= '0;
                imr_reg[c]   <= MASK_ALL;
                rss_reg[c]   <= 1'b0;
                phase_reg[c] <= PH_NORMAL;
                icw4_reg[c]  <= 1'b0;
            end
            base_reg[0] <= BASE_MASTER;
            base_reg[1] <= BASE_SLAVE;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                pend_reg <= pend_next;
                for (int c = 0; c < NUM_CHIPS; c++) begin
                    irr_reg[c]   <= irr_next[c];
                    isr_reg[c]   <= isr_next[c];
                    imr_reg[c]   <= imr_next[c];
                    base_reg[c]  <= base_next[c];
                    rss_reg[c]   <= rss_next[c];
                    phase_reg[c] <= phase_next[c];
                    icw4_reg[c]  <= icw4_next[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg <= item_t'({s_axis_tdata[13:0], s_axis_tuser});
        end
        if (fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.int_request,
                            out_res_reg.vector, out_res_reg.read_data};
    assign m_axis_tuser  = {out_res_reg.bad_irq, out_res_reg.vector_valid};

    logic [4:0] ack_probe;
    assign ack_probe = encode_priority(irr_reg[0] & ~isr_reg[0] & ~imr_reg[0],
                                       irr_reg[1] & ~isr_reg[1] & ~imr_reg[1]);

    a_ack_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[20:16] == 5'd0)
        else $error("acknowledge left the pending line set");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("vector and bad IRQ flagged together");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled with room to advance");

    a_ack_sets_service: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.action == ACT_ACK && !in_item_reg.irq_line[3]
        && (ack_probe != 5'd0) |=> (isr_reg[0] | isr_reg[1]) != 8'd0)
        else $error("acknowledge did not mark a line in service");

endmodule
